>>> design/nfps_pkg.sv
// Package: shared types and constants for the parent selection core.
`default_nettype none
package nfps_pkg;

    localparam logic [1:0] ACT_WR_NBR = 2'd0;
    localparam logic [1:0] ACT_WR_ALL = 2'd1;
    localparam logic [1:0] ACT_SELECT = 2'd2;
    localparam logic [1:0] ACT_COMMIT = 2'd3;

    localparam logic [15:0] WILD_WEIGHT = 16'd4096;
    localparam logic [15:0] FIT_RESET   = 16'd4096;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SUM, S_MUL, S_PICK, S_COPY, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_SUM, CMD_MUL, CMD_PICK, CMD_COPY, CMD_FINISH
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic sweep_done;
        logic total_zero;
        logic hit;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

>>> design/nfps_if.sv
// Interfaces: input and result channels with valid/ready handshake.
`default_nettype none
interface nfps_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  location;
    logic [7:0]  neighbour;
    logic        value_bit;
    logic [15:0] random_fraction;

    modport source (output valid, action, location, neighbour, value_bit, random_fraction,
                    input ready);
    modport sink (input valid, action, location, neighbour, value_bit, random_fraction,
                  output ready);
endinterface

interface nfps_out_if;
    logic        valid;
    logic        ready;
    logic        child_allele;
    logic [7:0]  selected_parent;
    logic        no_neighbour_error;
    logic        is_fixed;
    logic        fixed_allele;
    logic [31:0] generation_count;

    modport source (output valid, child_allele, selected_parent, no_neighbour_error,
                    is_fixed, fixed_allele, generation_count, input ready);
    modport sink (input valid, child_allele, selected_parent, no_neighbour_error,
                  is_fixed, fixed_allele, generation_count, output ready);
endinterface
`default_nettype wire

>>> design/nfps_ctrl.sv
// Controller: sequences clear, write, select and commit transactions.
`default_nettype none
module nfps_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire logic [1:0]       i_action,
    input  wire nfps_pkg::t_status i_status,
    output nfps_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready
);
    import nfps_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd = CMD_ACCEPT;
                    unique case (i_action)
                        ACT_SELECT: n_state = S_SUM;
                        ACT_COMMIT: n_state = S_COPY;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_SUM: begin
                o_cmd = CMD_SUM;
                if (i_status.sweep_done) n_state = i_status.total_zero ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd   = CMD_MUL;
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd = CMD_PICK;
                if (i_status.hit || i_status.sweep_done) n_state = S_DONE;
            end
            S_COPY: begin
                o_cmd = CMD_COPY;
                if (i_status.sweep_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end
endmodule
`default_nettype wire

>>> design/nfps_dp.sv
// Datapath: neighbour and allele memories, weight sums, pick and result register.
`default_nettype none
module nfps_dp #(
    parameter int POP_SIZE = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire nfps_pkg::t_cmd   i_cmd,
    output nfps_pkg::t_status     o_status,
    input  wire logic             i_cfg_we,
    input  wire logic [15:0]      i_cfg_data,
    input  wire logic [1:0]       i_action,
    input  wire logic [7:0]       i_location,
    input  wire logic [7:0]       i_neighbour,
    input  wire logic             i_value_bit,
    input  wire logic [15:0]      i_random_fraction,
    input  wire logic             i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_child_allele,
    output logic [7:0]            o_selected_parent,
    output logic                  o_no_neighbour_error,
    output logic                  o_is_fixed,
    output logic                  o_fixed_allele,
    output logic [31:0]           o_generation_count
);
    import nfps_pkg::*;

    localparam int LOG   = $clog2(POP_SIZE);
    localparam int DEPTH = POP_SIZE * POP_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = AW + 9;
    localparam int TW    = 16 + $clog2(POP_SIZE + 1);
    localparam int GW    = TW + 16;

    logic nbr_mem [DEPTH];
    logic cur_mem [POP_SIZE];
    logic nxt_mem [POP_SIZE];

    logic [15:0]     r_fit;
    logic [AW-1:0]   r_clr;
    logic [1:0]      r_kind;
    logic [7:0]      r_loc;
    logic [15:0]     r_frac;
    logic [LOG:0]    r_idx;
    logic            r_pend;
    logic [LOG-1:0]  r_pidx;
    logic            r_nb, r_cb, r_xb;
    logic [TW-1:0]   r_total, r_run;
    logic [GW-1:0]   r_target;
    logic            r_child, r_err, r_same, r_first;
    logic [LOG-1:0]  r_parent;
    logic [31:0]     r_gen;

    logic            loc_ok_rd, loc_ok_in, nb_ok_in, issue;
    logic [XW-1:0]   rd_ext, wr_ext;
    logic [AW-1:0]   rd_addr, wr_addr;
    logic [TW-1:0]   w, run_n;
    logic            hit;
    logic [LOG+7:0]  par_ext;

    assign loc_ok_rd = (XW'(r_loc) < XW'(POP_SIZE));
    assign loc_ok_in = (XW'(i_location) < XW'(POP_SIZE));
    assign nb_ok_in  = (XW'(i_neighbour) < XW'(POP_SIZE));
    assign rd_ext  = XW'(r_loc) * XW'(POP_SIZE) + XW'(r_idx[LOG-1:0]);
    assign wr_ext  = XW'(i_location) * XW'(POP_SIZE) + XW'(i_neighbour);
    assign rd_addr = rd_ext[AW-1:0];
    assign wr_addr = (i_cmd == CMD_CLEAR) ? r_clr : wr_ext[AW-1:0];
    assign issue   = (r_idx < (LOG+1)'(POP_SIZE));
    assign w       = r_cb ? TW'(r_fit) : TW'(WILD_WEIGHT);
    assign run_n   = r_run + w;
    assign hit     = r_pend && r_nb && (run_n != '0) && ({run_n, 16'h0} >= r_target);
    assign par_ext = {8'h00, r_parent};

    assign o_status.clear_done = (r_clr == AW'(DEPTH - 1));
    assign o_status.sweep_done = !issue && !r_pend;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.hit        = hit;
    assign o_status.out_free   = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if ((i_cmd == CMD_CLEAR) ||
            (i_cmd == CMD_ACCEPT && i_action == ACT_WR_NBR && loc_ok_in && nb_ok_in)) begin
            nbr_mem[wr_addr] <= (i_cmd == CMD_CLEAR) ? 1'b0 : i_value_bit;
        end
        r_nb <= nbr_mem[rd_addr];
        r_cb <= cur_mem[r_idx[LOG-1:0]];
        r_xb <= nxt_mem[r_idx[LOG-1:0]];
        if (i_cmd == CMD_CLEAR && r_clr < AW'(POP_SIZE)) begin
            cur_mem[r_clr[LOG-1:0]] <= 1'b0;
        end else if (i_cmd == CMD_ACCEPT && i_action == ACT_WR_ALL && loc_ok_in) begin
            cur_mem[LOG'(i_location)] <= i_value_bit;
        end else if (i_cmd == CMD_COPY && r_pend) begin
            cur_mem[r_pidx] <= r_xb;
        end
        if (i_cmd == CMD_CLEAR && r_clr < AW'(POP_SIZE)) begin
            nxt_mem[r_clr[LOG-1:0]] <= 1'b0;
        end else if (i_cmd == CMD_PICK && hit) begin
            nxt_mem[LOG'(r_loc)] <= r_cb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit       <= FIT_RESET;
            r_clr       <= '0;
            r_gen       <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_fit <= i_cfg_data;
            if (o_out_valid && i_out_ready && i_cmd != CMD_FINISH) o_out_valid <= 1'b0;
            case (i_cmd)
                CMD_CLEAR: r_clr <= r_clr + 1'b1;
                CMD_ACCEPT: begin
                    r_kind   <= i_action;
                    r_loc    <= i_location;
                    r_frac   <= i_random_fraction;
                    r_idx    <= '0;
                    r_pend   <= 1'b0;
                    r_total  <= '0;
                    r_child  <= 1'b0;
                    r_parent <= '0;
                    r_err    <= (i_action == ACT_SELECT);
                    r_same   <= 1'b1;
                    r_first  <= 1'b0;
                    if (i_action == ACT_COMMIT && r_gen != 32'hFFFF_FFFF) r_gen <= r_gen + 1'b1;
                end
                CMD_SUM, CMD_PICK, CMD_COPY: begin
                    if (issue) r_idx <= r_idx + 1'b1;
                    r_pend <= issue;
                    r_pidx <= r_idx[LOG-1:0];
                    if (i_cmd == CMD_SUM && r_pend && r_nb && loc_ok_rd) r_total <= r_total + w;
                    if (i_cmd == CMD_PICK && r_pend && r_nb) r_run <= run_n;
                    if (i_cmd == CMD_PICK && hit) begin
                        r_child  <= r_cb;
                        r_parent <= r_pidx;
                        r_err    <= 1'b0;
                    end
                    if (i_cmd == CMD_COPY && r_pend) begin
                        if (r_pidx == '0) r_first <= r_xb;
                        else if (r_xb != r_first) r_same <= 1'b0;
                    end
                end
                CMD_MUL: begin
                    r_target <= GW'(r_frac) * GW'(r_total);
                    r_idx    <= '0;
                    r_pend   <= 1'b0;
                    r_run    <= '0;
                end
                CMD_FINISH: begin
                    o_out_valid          <= 1'b1;
                    o_child_allele       <= r_child;
                    o_selected_parent    <= par_ext[7:0];
                    o_no_neighbour_error <= r_err;
                    o_is_fixed           <= (r_kind == ACT_COMMIT) && r_same;
                    o_fixed_allele       <= (r_kind == ACT_COMMIT) && r_same && r_first;
                    o_generation_count   <= r_gen;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> design/network_fitness_parent_selection_core.sv
// Top level: parent selection core with controller and datapath.
// Write transactions: the result loads in S_DONE when the output is free.
// Select: a summing sweep and then a pick sweep over one neighbour row.
// Commit: a copy sweep over the allele memory.
// After reset a clearing pass zeroes the memories; no transaction is accepted
// during it. Synchronous active-low reset.
`default_nettype none
module network_fitness_parent_selection_core #(
    parameter int POP_SIZE = 256
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    nfps_in_if.sink    i_in,
    nfps_out_if.source o_out
);
    import nfps_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready = in_ready;

    nfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    nfps_dp #(.POP_SIZE(POP_SIZE)) u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_status             (status),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_data           (i_cfg_data),
        .i_action             (i_in.action),
        .i_location           (i_in.location),
        .i_neighbour          (i_in.neighbour),
        .i_value_bit          (i_in.value_bit),
        .i_random_fraction    (i_in.random_fraction),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_child_allele       (o_out.child_allele),
        .o_selected_parent    (o_out.selected_parent),
        .o_no_neighbour_error (o_out.no_neighbour_error),
        .o_is_fixed           (o_out.is_fixed),
        .o_fixed_allele       (o_out.fixed_allele),
        .o_generation_count   (o_out.generation_count)
    );
endmodule
`default_nettype wire

>>> tb/nfps_checker.sv
// Checker: watches both channels, predicts each result and compares it.
`timescale 1ns / 1ps
`default_nettype none
module nfps_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    nfps_in_if               i_in_mon,
    nfps_out_if              i_out_mon,
    output int               o_errors,
    output int               o_pending
);
    import nfps_pkg::*;

    localparam int NPOP = 256;

    typedef struct {
        bit        child;
        bit [7:0]  parent;
        bit        err;
        bit        fixd;
        bit        fall;
        bit [31:0] gens;
    } t_result;

    bit        link[NPOP][NPOP];
    bit        cur_allele[NPOP];
    bit        next_allele[NPOP];
    bit [31:0] gen_count;
    bit [15:0] fitness;
    t_result   expected_results[$];

    function automatic bit [63:0] weight(int idx);
        return cur_allele[idx] ? 64'(fitness) : 64'(WILD_WEIGHT);
    endfunction

    function automatic t_result predict_result(logic [1:0] act, logic [7:0] loc,
                                               logic [7:0] nb, logic b, logic [15:0] frac);
        t_result   r;
        bit [63:0] total;
        bit [63:0] run;
        bit [63:0] target;
        bit        same;
        r = '{default: 0};
        total = 0;
        run = 0;
        case (act)
            ACT_WR_NBR: link[loc][nb] = b;
            ACT_WR_ALL: cur_allele[loc] = b;
            ACT_SELECT: begin
                r.err = 1'b1;
                for (int j = 0; j < NPOP; j++)
                    if (link[loc][j]) total += weight(j);
                if (total != 0) begin
                    target = 64'(frac) * total;
                    for (int j = 0; j < NPOP; j++) begin
                        if (link[loc][j]) begin
                            run += weight(j);
                            if (run > 0 && (run << 16) >= target) begin
                                next_allele[loc] = cur_allele[j];
                                r.child = cur_allele[j];
                                r.parent = 8'(j);
                                r.err = 1'b0;
                                break;
                            end
                        end
                    end
                end
            end
            default: begin
                cur_allele = next_allele;
                if (gen_count != 32'hFFFF_FFFF) gen_count++;
                same = 1'b1;
                for (int i = 1; i < NPOP; i++)
                    if (cur_allele[i] != cur_allele[0]) same = 1'b0;
                r.fixd = same;
                r.fall = same & cur_allele[0];
            end
        endcase
        r.gens = gen_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            foreach (link[i, j]) link[i][j] = 1'b0;
            foreach (cur_allele[i]) begin
                cur_allele[i] = 1'b0;
                next_allele[i] = 1'b0;
            end
            gen_count = 0;
            fitness = FIT_RESET;
            o_errors = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_we) fitness = i_cfg_data;
            if (i_in_mon.valid && i_in_mon.ready)
                expected_results.push_back(predict_result(i_in_mon.action, i_in_mon.location,
                    i_in_mon.neighbour, i_in_mon.value_bit, i_in_mon.random_fraction));
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    o_errors++;
                end else begin
                    e = expected_results.pop_front();
                    check_field("child_allele", 32'(e.child), 32'(i_out_mon.child_allele));
                    check_field("selected_parent", 32'(e.parent),
                                32'(i_out_mon.selected_parent));
                    check_field("no_neighbour_error", 32'(e.err),
                                32'(i_out_mon.no_neighbour_error));
                    check_field("is_fixed", 32'(e.fixd), 32'(i_out_mon.is_fixed));
                    check_field("fixed_allele", 32'(e.fall), 32'(i_out_mon.fixed_allele));
                    check_field("generation_count", e.gens, i_out_mon.generation_count);
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule
`default_nettype wire

>>> tb/tb_network_fitness_parent_selection_core.sv
// Testbench top: clock, reset, stimulus, idling and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_network_fitness_parent_selection_core;
    import nfps_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    int          errors;
    int          pending;
    int          tx_idle = 20;
    int          rx_idle = 86;

    nfps_in_if  in_ch();
    nfps_out_if out_ch();

    network_fitness_parent_selection_core #(.POP_SIZE(256)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    nfps_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_mon(in_ch), .i_out_mon(out_ch), .o_errors(errors), .o_pending(pending)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    task automatic put(logic [1:0] act, logic [7:0] loc, logic [7:0] nb, logic b,
                       logic [15:0] frac);
        while ($urandom_range(99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.location <= loc;
        in_ch.neighbour <= nb;
        in_ch.value_bit <= b;
        in_ch.random_fraction <= frac;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_fitness(logic [15:0] v);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        logic [7:0]  loc;
        logic [15:0] frac;
        int          roll;
        roll = $urandom_range(99);
        loc = ($urandom_range(99) < 80) ? 8'($urandom_range(15)) : 8'($urandom_range(255));
        case ($urandom_range(9))
            0: frac = 16'd0;
            1: frac = 16'hFFFF;
            default: frac = 16'($urandom_range(65535));
        endcase
        if (roll < 45)
            put(ACT_WR_NBR, loc, 8'($urandom_range(255)), $urandom_range(99) < 70, frac);
        else if (roll < 60)
            put(ACT_WR_ALL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                1'($urandom_range(1)), frac);
        else if (roll < 92)
            put(ACT_SELECT, loc, 8'($urandom_range(255)), 1'($urandom_range(1)), frac);
        else
            put(ACT_COMMIT, loc, 8'($urandom_range(255)), 1'($urandom_range(1)), frac);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = ACT_WR_NBR;
        in_ch.location = '0;
        in_ch.neighbour = '0;
        in_ch.value_bit = 1'b0;
        in_ch.random_fraction = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes of the fields, every action, empty row and zero total weight
        put(ACT_COMMIT, 8'd0, 8'd0, 1'b0, 16'd0);
        put(ACT_WR_NBR, 8'd5, 8'd0, 1'b1, 16'd0);
        put(ACT_WR_NBR, 8'd5, 8'd255, 1'b1, 16'hFFFF);
        put(ACT_WR_NBR, 8'd5, 8'd7, 1'b1, 16'd0);
        put(ACT_WR_ALL, 8'd255, 8'd255, 1'b1, 16'd0);
        put(ACT_WR_ALL, 8'd0, 8'd0, 1'b0, 16'd0);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'd0);
        put(ACT_SELECT, 8'd5, 8'd255, 1'b1, 16'hFFFF);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'h8000);
        put(ACT_SELECT, 8'd200, 8'd0, 1'b0, 16'h1234);
        put(ACT_SELECT, 8'd255, 8'd0, 1'b0, 16'hFFFF);
        put(ACT_WR_NBR, 8'd9, 8'd255, 1'b1, 16'd0);
        put(ACT_COMMIT, 8'd255, 8'd255, 1'b1, 16'hFFFF);
        set_fitness(16'd0);
        put(ACT_SELECT, 8'd9, 8'd0, 1'b0, 16'd100);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'hFFFF);
        put(ACT_WR_NBR, 8'd5, 8'd7, 1'b0, 16'd0);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'hFFFF);
        put(ACT_COMMIT, 8'd0, 8'd0, 1'b0, 16'd0);
        set_fitness(16'hFFFF);
        put(ACT_SELECT, 8'd9, 8'd0, 1'b0, 16'hFFFF);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'hFFFF);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle = (phase == 0) ? 20 : (phase == 1) ? 86 : 0;
            rx_idle = (phase == 0) ? 86 : (phase == 1) ? 20 : 0;
            set_fitness((phase == 1) ? 16'hFFFF : 16'($urandom_range(65535)));
            for (int n = 0; n < 383; n++) begin
                if (phase == 0 && n == 190) drain();
                random_item();
            end
        end
        set_fitness(FIT_RESET);
        put(ACT_SELECT, 8'd5, 8'd0, 1'b0, 16'h4000);

        drain();
        repeat (600) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #40ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire
